// ===== design/lbp_pkg.sv =====
package lbp_pkg;

    // default line store and frame limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    // field widths
    localparam int PIX_W        = 8;
    localparam int ROW_W        = 12;
    localparam int COL_W        = 10;
    localparam int CODE_W       = 8;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;

    // register reset values
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // number of result slots per pixel
    localparam int NUM_SLOTS = 4;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    // position of one pixel inside the frame
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             row_end;
        logic             frame_end;
    } t_pos;

    // 3x3 window, grid[y][x], y = 0 is two rows above
    typedef logic [2:0][2:0][PIX_W-1:0] t_grid;

    // one column of the window, [0] two rows above, [2] newest pixel
    typedef logic [2:0][PIX_W-1:0] t_column;

    typedef logic [NUM_SLOTS-1:0][CODE_W-1:0] t_codes;

    // neighbor offsets, clockwise from top-left
    localparam int NB_DY [8] = '{-1, -1, -1, 0, 1, 1, 1, 0};
    localparam int NB_DX [8] = '{-1, 0, 1, 1, 1, 0, -1, -1};

    // lbp code of the center at grid (cy, cx); row_ok/col_ok mark grid
    // rows/columns that lie inside the frame
    function automatic logic [CODE_W-1:0] lbp_code(
        input t_grid      grid,
        input int         cy,
        input int         cx,
        input logic [2:0] row_ok,
        input logic [2:0] col_ok
    );
        logic [CODE_W-1:0] code;
        logic [PIX_W-1:0]  center;
        int                ny;
        int                nx;
        code   = '0;
        center = grid[cy][cx];
        for (int k = 0; k < 8; k++) begin
            ny = cy + NB_DY[k];
            nx = cx + NB_DX[k];
            if (ny >= 0 && ny <= 2 && nx >= 0 && nx <= 2) begin
                if (row_ok[ny] && col_ok[nx] && grid[ny][nx] >= center) begin
                    code[CODE_W-1-k] = 1'b1;
                end
            end
        end
        return code;
    endfunction

endpackage

// ===== design/lbp_ram.sv =====
module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/lbp_pos_counter.sv =====
module lbp_pos_counter #(
    parameter int MAX_WIDTH  = lbp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lbp_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  lbp_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_adv,
    output lbp_pkg::t_pos                   o_pos
);

    logic [lbp_pkg::WIDTH_REG_W-1:0]  r_width;
    logic [lbp_pkg::HEIGHT_REG_W-1:0] r_height;
    logic [lbp_pkg::COL_W-1:0]        r_col;
    logic [lbp_pkg::ROW_W-1:0]        r_row;
    logic [lbp_pkg::COL_W-1:0]        n_col;
    logic [lbp_pkg::ROW_W-1:0]        n_row;

    logic [lbp_pkg::WIDTH_REG_W-1:0]  w_used;
    logic [lbp_pkg::HEIGHT_REG_W-1:0] h_used;
    logic [lbp_pkg::WIDTH_REG_W-1:0]  w_last;
    logic [lbp_pkg::HEIGHT_REG_W-1:0] h_last;
    logic [lbp_pkg::COL_W-1:0]        jc;
    logic [lbp_pkg::ROW_W-1:0]        ic;
    logic                             row_end;
    logic                             frame_end;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= lbp_pkg::WIDTH_REG_W'(lbp_pkg::WIDTH_RESET);
            r_height <= lbp_pkg::HEIGHT_REG_W'(lbp_pkg::HEIGHT_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lbp_pkg::REG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_wdata[lbp_pkg::WIDTH_REG_W-1:0];
                end
                lbp_pkg::REG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_wdata[lbp_pkg::HEIGHT_REG_W-1:0];
                end
                default: begin
                    r_width <= r_width;
                end
            endcase
        end
    end

    // clamp frame size to 1..max
    always_comb begin
        if (r_width == '0) begin
            w_used = lbp_pkg::WIDTH_REG_W'(1);
        end else if (r_width > MAX_WIDTH) begin
            w_used = lbp_pkg::WIDTH_REG_W'(MAX_WIDTH);
        end else begin
            w_used = r_width;
        end
        if (r_height == '0) begin
            h_used = lbp_pkg::HEIGHT_REG_W'(1);
        end else if (r_height > MAX_HEIGHT) begin
            h_used = lbp_pkg::HEIGHT_REG_W'(MAX_HEIGHT);
        end else begin
            h_used = r_height;
        end
    end

    assign w_last = w_used - lbp_pkg::WIDTH_REG_W'(1);
    assign h_last = h_used - lbp_pkg::HEIGHT_REG_W'(1);

    // position of this pixel, pulled back into a shrunk frame
    assign jc = ({1'b0, r_col} >= w_used) ? w_last[lbp_pkg::COL_W-1:0] : r_col;
    assign ic = ({1'b0, r_row} >= h_used) ? h_last[lbp_pkg::ROW_W-1:0] : r_row;
    assign row_end   = ({1'b0, jc} == w_last);
    assign frame_end = ({1'b0, ic} == h_last);

    assign o_pos.col       = jc;
    assign o_pos.row       = ic;
    assign o_pos.row_end   = row_end;
    assign o_pos.frame_end = frame_end;

    // raster counters
    always_comb begin
        if (row_end) begin
            n_col = '0;
            n_row = frame_end ? '0 : ic + lbp_pkg::ROW_W'(1);
        end else begin
            n_col = jc + lbp_pkg::COL_W'(1);
            n_row = ic;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_adv) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== design/lbp_code_calc.sv =====
module lbp_code_calc (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  lbp_pkg::t_column i_cur,
    input  lbp_pkg::t_pos    i_pos,
    output lbp_pkg::t_codes  o_codes
);

    // two previous columns of the window, [y][0] older
    logic [2:0][1:0][lbp_pkg::PIX_W-1:0] r_win;
    lbp_pkg::t_grid                      grid;
    logic [2:0]                          row_ok;
    logic [2:0]                          col_ok;

    // shift the window by one column per pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_load) begin
            for (int y = 0; y < 3; y++) begin
                r_win[y][0] <= r_win[y][1];
                r_win[y][1] <= i_cur[y];
            end
        end
    end

    // assemble the 3x3 grid
    always_comb begin
        for (int y = 0; y < 3; y++) begin
            grid[y][0] = r_win[y][0];
            grid[y][1] = r_win[y][1];
            grid[y][2] = i_cur[y];
        end
    end

    // window rows/columns inside the frame
    assign row_ok = {1'b1, i_pos.row != '0, i_pos.row > lbp_pkg::ROW_W'(1)};
    assign col_ok = {1'b1, i_pos.col != '0, i_pos.col > lbp_pkg::COL_W'(1)};

    // four candidate centers, row-major
    assign o_codes[0] = lbp_pkg::lbp_code(grid, 1, 1, row_ok, col_ok);
    assign o_codes[1] = lbp_pkg::lbp_code(grid, 1, 2, row_ok, col_ok);
    assign o_codes[2] = lbp_pkg::lbp_code(grid, 2, 1, row_ok, col_ok);
    assign o_codes[3] = lbp_pkg::lbp_code(grid, 2, 2, row_ok, col_ok);

endmodule

// ===== design/lbp_result_buf.sv =====
module lbp_result_buf (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  lbp_pkg::t_codes              i_codes,
    input  lbp_pkg::t_pos                i_pos,
    output logic                         o_free,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [lbp_pkg::ROW_W-1:0]    o_row,
    output logic [lbp_pkg::COL_W-1:0]    o_column,
    output logic [lbp_pkg::CODE_W-1:0]   o_code,
    output logic                         o_last
);

    logic [lbp_pkg::NUM_SLOTS-1:0] r_pend;
    logic [lbp_pkg::NUM_SLOTS-1:0] n_pend;
    lbp_pkg::t_codes               r_codes;
    logic [lbp_pkg::ROW_W-1:0]     r_row;
    logic [lbp_pkg::COL_W-1:0]     r_col;

    logic [lbp_pkg::NUM_SLOTS-1:0] mask;
    logic [lbp_pkg::NUM_SLOTS-1:0] sel_bit;
    logic [1:0]                    sel;
    logic                          take;
    logic                          row_upper;
    logic                          row_lower;
    logic                          c_left;
    logic                          c_right;

    // slots that this pixel fills: bit1 of slot picks the lower row,
    // bit0 the right column
    assign row_upper = i_pos.row != '0;
    assign row_lower = i_pos.frame_end;
    assign c_left    = i_pos.col != '0;
    assign c_right   = i_pos.row_end;
    assign mask      = {row_lower & c_right, row_lower & c_left,
                        row_upper & c_right, row_upper & c_left};

    // first pending slot
    always_comb begin
        if (r_pend[0]) begin
            sel = 2'd0;
        end else if (r_pend[1]) begin
            sel = 2'd1;
        end else if (r_pend[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
    end

    assign sel_bit = lbp_pkg::NUM_SLOTS'(1) << sel;
    assign o_valid = r_pend != '0;
    assign take    = o_valid && i_ready;
    assign o_last  = (r_pend & ~sel_bit) == '0;
    assign o_free  = !o_valid || (take && o_last);

    // result fields of the shown slot
    assign o_row    = sel[1] ? r_row : r_row - lbp_pkg::ROW_W'(1);
    assign o_column = sel[0] ? r_col : r_col - lbp_pkg::COL_W'(1);
    assign o_code   = r_codes[sel];

    // pending mask
    always_comb begin
        if (i_load) begin
            n_pend = mask;
        end else if (take) begin
            n_pend = r_pend & ~sel_bit;
        end else begin
            n_pend = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    // payload of a new pixel's results
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_codes <= i_codes;
            r_row   <= i_pos.row;
            r_col   <= i_pos.col;
        end
    end

endmodule

// ===== design/lbp_pixel_code_unit.sv =====
// a pixel passes the stage 1 register, then its codes load into the output buffer
// throughput: one pixel per cycle unless the output stalls; results drain one per
//   cycle, so a pixel giving over one code (row end, last row) holds input
// reset: synchronous, active low; clears counters, window and buffers, loads
//   width 640 and height 480; line stores are not cleared and need no clearing pass
module lbp_pixel_code_unit #(
    parameter int MAX_WIDTH  = lbp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lbp_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [lbp_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [lbp_pkg::PIX_W-1:0]      i_pixel,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [lbp_pkg::ROW_W-1:0]      o_row,
    output logic [lbp_pkg::COL_W-1:0]      o_column,
    output logic [lbp_pkg::CODE_W-1:0]     o_code,
    output logic                           o_last
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    lbp_pkg::t_pos               pos;
    logic                        accept;
    logic                        s1_fire;
    logic                        buf_free;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               s1_addr;
    logic [lbp_pkg::PIX_W-1:0]   ram_above_q;
    logic [lbp_pkg::PIX_W-1:0]   ram_two_q;
    logic [lbp_pkg::PIX_W-1:0]   col_above;
    logic [lbp_pkg::PIX_W-1:0]   col_two;
    lbp_pkg::t_column            cur;
    lbp_pkg::t_codes             codes;

    logic                        r_s1_valid;
    logic [lbp_pkg::PIX_W-1:0]   r_s1_pix;
    lbp_pkg::t_pos               r_s1_pos;
    logic                        r_fwd;
    logic [lbp_pkg::PIX_W-1:0]   r_fwd_above;
    logic [lbp_pkg::PIX_W-1:0]   r_fwd_two;

    // handshake
    assign s1_fire = r_s1_valid && buf_free;
    assign o_ready = !r_s1_valid || s1_fire;
    assign accept  = i_valid && o_ready;

    // frame position and config registers
    lbp_pos_counter #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (lbp_pkg::t_cfg_idx'(i_cfg_idx)),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (accept),
        .o_pos       (pos)
    );

    assign rd_addr = AW'(pos.col);
    assign s1_addr = AW'(r_s1_pos.col);

    // line stores: read on the beat, written back when the pixel leaves stage 1
    lbp_ram #(
        .WIDTH (lbp_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (s1_addr),
        .i_wdata (r_s1_pix),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_above_q)
    );

    lbp_ram #(
        .WIDTH (lbp_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_two_above (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (s1_addr),
        .i_wdata (col_above),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_two_q)
    );

    // bypass when a read hits the entry being written, as in a one-pixel-wide frame
    assign col_above = r_fwd ? r_fwd_above : ram_above_q;
    assign col_two   = r_fwd ? r_fwd_two   : ram_two_q;

    // stage 1 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= s1_fire && (s1_addr == rd_addr);
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix    <= i_pixel;
            r_s1_pos    <= pos;
            r_fwd_above <= r_s1_pix;
            r_fwd_two   <= col_above;
        end
    end

    assign cur[0] = col_two;
    assign cur[1] = col_above;
    assign cur[2] = r_s1_pix;

    // window and the four candidate codes
    lbp_code_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_fire),
        .i_cur   (cur),
        .i_pos   (r_s1_pos),
        .o_codes (codes)
    );

    // output buffer
    lbp_result_buf u_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s1_fire),
        .i_codes  (codes),
        .i_pos    (r_s1_pos),
        .o_free   (buf_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_row    (o_row),
        .o_column (o_column),
        .o_code   (o_code),
        .o_last   (o_last)
    );

`ifndef ASSERT_OFF
    // a stalled pixel keeps its place in stage 1
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_fire) |=> (r_s1_valid && $stable(r_s1_pos)))
        else $error("stage 1 pixel lost while stalled");

    // an accepted pixel lands in stage 1
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_s1_valid)
        else $error("accepted pixel missing from stage 1");

    // new results load only as the last pending one leaves
    a_load_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && o_valid) |-> (i_ready && o_last))
        else $error("result buffer overwritten");
`endif

endmodule

// ===== dv/lbp_code_checker.sv =====
module lbp_code_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_idx,
    input  wire logic [lbp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire logic                              i_pix_valid,
    input  wire logic                              i_pix_ready,
    input  wire logic [lbp_pkg::PIX_W-1:0]         i_pixel,
    input  wire logic                              i_code_valid,
    input  wire logic                              i_code_ready,
    input  wire logic [lbp_pkg::ROW_W-1:0]         i_row,
    input  wire logic [lbp_pkg::COL_W-1:0]         i_column,
    input  wire logic [lbp_pkg::CODE_W-1:0]        i_code,
    input  wire logic                              i_last,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // one code beat as it should leave the block
    typedef struct packed {
        logic [lbp_pkg::ROW_W-1:0]  row;
        logic [lbp_pkg::COL_W-1:0]  column;
        logic [lbp_pkg::CODE_W-1:0] code;
        logic                       last;
    } t_code_beat;

    // neighbor ring, clockwise from top-left, weight 128 down to 1
    localparam int RING_DY [8] = '{-1, -1, -1, 0, 1, 1, 1, 0};
    localparam int RING_DX [8] = '{-1, 0, 1, 1, 1, 0, -1, -1};

    logic [lbp_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [lbp_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic [lbp_pkg::PIX_W-1:0]        row_prev  [lbp_pkg::MAX_WIDTH_DEF];
    logic [lbp_pkg::PIX_W-1:0]        row_prev2 [lbp_pkg::MAX_WIDTH_DEF];
    logic [lbp_pkg::PIX_W-1:0]        left_cols [3][2];
    int                               col_pos;
    int                               row_pos;
    t_code_beat                       code_q [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    // code of the center at win[cy][cx]; top_row/left_col are the frame
    // coordinates of win[0][0], negative ones lie outside the frame
    function automatic logic [lbp_pkg::CODE_W-1:0] neighbor_pattern(
        input logic [lbp_pkg::PIX_W-1:0] win [3][3],
        input int                        cy,
        input int                        cx,
        input int                        top_row,
        input int                        left_col
    );
        logic [lbp_pkg::CODE_W-1:0] pattern;
        int                         ny;
        int                         nx;
        pattern = '0;
        for (int k = 0; k < 8; k++) begin
            ny = cy + RING_DY[k];
            nx = cx + RING_DX[k];
            if (ny <= 2 && nx <= 2 && top_row + ny >= 0 && left_col + nx >= 0) begin
                if (win[ny][nx] >= win[cy][cx]) begin
                    pattern[lbp_pkg::CODE_W-1-k] = 1'b1;
                end
            end
        end
        return pattern;
    endfunction

    // codes completed by one accepted pixel, then advance the window
    task automatic predict_codes(input logic [lbp_pkg::PIX_W-1:0] px);
        int                        w;
        int                        h;
        int                        jc;
        int                        ic;
        int                        nr;
        int                        nc;
        int                        rows [2];
        int                        cols [2];
        bit                        row_end;
        bit                        frame_end;
        logic [lbp_pkg::PIX_W-1:0] fresh [3];
        logic [lbp_pkg::PIX_W-1:0] win [3][3];
        t_code_beat                beat;

        w = (width_reg == 0) ? 1 :
            (width_reg > lbp_pkg::MAX_WIDTH_DEF) ? lbp_pkg::MAX_WIDTH_DEF :
            int'(width_reg);
        h = (height_reg == 0) ? 1 :
            (height_reg > lbp_pkg::MAX_HEIGHT_DEF) ? lbp_pkg::MAX_HEIGHT_DEF :
            int'(height_reg);
        // a position past a shrunk frame is pulled back to its last column/row
        jc = (col_pos >= w) ? w - 1 : col_pos;
        ic = (row_pos >= h) ? h - 1 : row_pos;
        row_end   = (jc == w - 1);
        frame_end = (ic == h - 1);

        fresh[0] = row_prev2[jc];
        fresh[1] = row_prev[jc];
        fresh[2] = px;
        for (int y = 0; y < 3; y++) begin
            win[y][0] = left_cols[y][0];
            win[y][1] = left_cols[y][1];
            win[y][2] = fresh[y];
        end

        // centers: row above always once past row 0, current row on the last row
        nr = 0;
        nc = 0;
        if (ic >= 1) begin
            rows[nr] = 1;
            nr++;
        end
        if (frame_end) begin
            rows[nr] = 2;
            nr++;
        end
        if (jc >= 1) begin
            cols[nc] = 1;
            nc++;
        end
        if (row_end) begin
            cols[nc] = 2;
            nc++;
        end

        for (int a = 0; a < nr; a++) begin
            for (int b = 0; b < nc; b++) begin
                beat.row    = lbp_pkg::ROW_W'(ic - 2 + rows[a]);
                beat.column = lbp_pkg::COL_W'(jc - 2 + cols[b]);
                beat.code   = neighbor_pattern(win, rows[a], cols[b], ic - 2, jc - 2);
                beat.last   = (a == nr - 1) && (b == nc - 1);
                code_q.push_back(beat);
            end
        end

        // line stores and window shift
        row_prev2[jc] = fresh[1];
        row_prev[jc]  = px;
        for (int y = 0; y < 3; y++) begin
            left_cols[y][0] = left_cols[y][1];
            left_cols[y][1] = fresh[y];
        end

        if (row_end) begin
            col_pos = 0;
            row_pos = frame_end ? 0 : ic + 1;
        end else begin
            col_pos = jc + 1;
            row_pos = ic;
        end
    endtask

    task automatic check_beat(input t_code_beat want);
        if (i_row !== want.row)
            report_mismatch($sformatf("row got %0d expected %0d", i_row, want.row));
        if (i_column !== want.column)
            report_mismatch($sformatf("column got %0d expected %0d (row %0d)",
                                      i_column, want.column, want.row));
        if (i_code !== want.code)
            report_mismatch($sformatf("code got %0d expected %0d (row %0d col %0d)",
                                      i_code, want.code, want.row, want.column));
        if (i_last !== want.last)
            report_mismatch($sformatf("last got %0b expected %0b (row %0d col %0d)",
                                      i_last, want.last, want.row, want.column));
    endtask

    // watch config, pixel and code channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = lbp_pkg::WIDTH_REG_W'(lbp_pkg::WIDTH_RESET);
            height_reg = lbp_pkg::HEIGHT_REG_W'(lbp_pkg::HEIGHT_RESET);
            col_pos    = 0;
            row_pos    = 0;
            for (int x = 0; x < lbp_pkg::MAX_WIDTH_DEF; x++) begin
                row_prev[x]  = '0;
                row_prev2[x] = '0;
            end
            for (int y = 0; y < 3; y++) begin
                left_cols[y][0] = '0;
                left_cols[y][1] = '0;
            end
            code_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (lbp_pkg::t_cfg_idx'(i_cfg_idx) == lbp_pkg::REG_IMAGE_WIDTH) begin
                    width_reg = i_cfg_wdata[lbp_pkg::WIDTH_REG_W-1:0];
                end else begin
                    height_reg = i_cfg_wdata[lbp_pkg::HEIGHT_REG_W-1:0];
                end
            end
            if (i_pix_valid && i_pix_ready) begin
                predict_codes(i_pixel);
            end
            if (i_code_valid && i_code_ready) begin
                if (code_q.size() == 0) begin
                    report_mismatch($sformatf(
                        "code beat with nothing pending: row %0d col %0d code %0d",
                        i_row, i_column, i_code));
                end else begin
                    check_beat(code_q.pop_front());
                end
            end
        end
        o_pending = code_q.size();
    end

endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PIXELS = 240;
    localparam int WIDE_PIXELS   = 40;
    localparam int TALL_PIXELS   = 40;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 10;
    localparam int TIMEOUT_NS    = 8_000_000;

    // mixed extremes and equal values around the center
    localparam logic [lbp_pkg::PIX_W-1:0] MIXED_3X3 [9] = '{
        8'd255, 8'd0,   8'd128,
        8'd128, 8'd128, 8'd127,
        8'd0,   8'd255, 8'd128
    };

    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           cfg_we     = 1'b0;
    lbp_pkg::t_cfg_idx              cfg_idx    = lbp_pkg::REG_IMAGE_WIDTH;
    logic [lbp_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;
    logic                           pix_valid  = 1'b0;
    logic [lbp_pkg::PIX_W-1:0]      pixel      = '0;
    logic                           code_ready = 1'b0;
    logic                           pix_ready;
    logic                           code_valid;
    logic [lbp_pkg::ROW_W-1:0]      code_row;
    logic [lbp_pkg::COL_W-1:0]      code_col;
    logic [lbp_pkg::CODE_W-1:0]     code_val;
    logic                           code_last;
    int                             fail_count;
    int                             pending;
    bit                             calm = 1'b0;

    lbp_pixel_code_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_valid     (pix_valid),
        .o_ready     (pix_ready),
        .i_pixel     (pixel),
        .o_valid     (code_valid),
        .i_ready     (code_ready),
        .o_row       (code_row),
        .o_column    (code_col),
        .o_code      (code_val),
        .o_last      (code_last)
    );

    lbp_code_checker u_code_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_pix_valid  (pix_valid),
        .i_pix_ready  (pix_ready),
        .i_pixel      (pixel),
        .i_code_valid (code_valid),
        .i_code_ready (code_ready),
        .i_row        (code_row),
        .i_column     (code_col),
        .i_code       (code_val),
        .i_last       (code_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("lbp_pixel_code_unit verification failed");
        $finish;
    end

    // gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // pixel mix: near-equal values, rails, full range
    function automatic logic [lbp_pkg::PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 3))
            0:       return lbp_pkg::PIX_W'($urandom_range(126, 130));
            1:       return $urandom_range(0, 1) ? 8'hff : 8'h00;
            default: return lbp_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // code receiver stalls
    initial begin : code_sink
        int gap;
        @(negedge clk);
        forever begin
            gap = idle_len();
            if (gap > 0) begin
                code_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            code_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_pixel(input logic [lbp_pkg::PIX_W-1:0] value);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_valid <= 1'b1;
        pixel     <= value;
        do @(posedge clk); while (!pix_ready);
        @(negedge clk);
    endtask

    task automatic send_pixels(input int count);
        repeat (count) send_pixel(pick_pixel());
    endtask

    // all codes out, then let a pixel with no code clear the pipe
    task automatic wait_for_idle();
        pix_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input lbp_pkg::t_cfg_idx idx,
                             input logic [lbp_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial begin : stimulus
        int w;
        int h;
        int frames;
        int sent;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero registers clamp to one-pixel frames, every neighbor outside
        write_reg(lbp_pkg::REG_IMAGE_WIDTH, '0);
        write_reg(lbp_pkg::REG_IMAGE_HEIGHT, '0);
        send_pixel(8'h00);
        send_pixel(8'hff);
        wait_for_idle();

        // small frame with rails and ties against the center
        write_reg(lbp_pkg::REG_IMAGE_WIDTH, lbp_pkg::CFG_DATA_W'(3));
        write_reg(lbp_pkg::REG_IMAGE_HEIGHT, lbp_pkg::CFG_DATA_W'(3));
        foreach (MIXED_3X3[k]) send_pixel(MIXED_3X3[k]);
        wait_for_idle();

        // width shrinks mid-row, row ends early at the new last column
        write_reg(lbp_pkg::REG_IMAGE_WIDTH, lbp_pkg::CFG_DATA_W'(5));
        send_pixels(3);
        wait_for_idle();
        write_reg(lbp_pkg::REG_IMAGE_WIDTH, lbp_pkg::CFG_DATA_W'(2));
        send_pixels(5);
        wait_for_idle();

        // height shrinks mid-frame, current row becomes the last one
        write_reg(lbp_pkg::REG_IMAGE_HEIGHT, lbp_pkg::CFG_DATA_W'(5));
        send_pixels(6);
        wait_for_idle();
        write_reg(lbp_pkg::REG_IMAGE_HEIGHT, lbp_pkg::CFG_DATA_W'(2));
        send_pixels(2);

        // random small frames, unused width bits toggled
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            w      = $urandom_range(1, 12);
            h      = $urandom_range(1, 8);
            frames = $urandom_range(1, 2);
            wait_for_idle();
            calm = ($urandom_range(0, 3) == 0);
            write_reg(lbp_pkg::REG_IMAGE_WIDTH, {2'($urandom_range(0, 3)), 11'(w)});
            write_reg(lbp_pkg::REG_IMAGE_HEIGHT, lbp_pkg::CFG_DATA_W'(h));
            send_pixels(frames * w * h);
            sent += frames * w * h;
        end

        // oversize width clamps to the line store, no early row end
        wait_for_idle();
        calm = ($urandom_range(0, 1) == 0);
        write_reg(lbp_pkg::REG_IMAGE_WIDTH, lbp_pkg::CFG_DATA_W'(13'h07ff));
        write_reg(lbp_pkg::REG_IMAGE_HEIGHT, lbp_pkg::CFG_DATA_W'(1));
        send_pixels(WIDE_PIXELS);

        // one column, all-ones height clamps to the limit, column pulled back
        wait_for_idle();
        calm = ($urandom_range(0, 1) == 0);
        write_reg(lbp_pkg::REG_IMAGE_WIDTH, lbp_pkg::CFG_DATA_W'(13'h1801));
        write_reg(lbp_pkg::REG_IMAGE_HEIGHT, lbp_pkg::CFG_DATA_W'(13'h1fff));
        send_pixels(TALL_PIXELS);

        wait_for_idle();
        repeat (END_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("lbp_pixel_code_unit verification clean");
        end else begin
            $display("lbp_pixel_code_unit verification failed");
        end
        $finish;
    end

endmodule
